// File: sv/i2a_pkg.sv
`default_nettype none

package i2a_pkg;

    // conversion kinds
    localparam logic [2:0] FN_D  = 3'd0;
    localparam logic [2:0] FN_U  = 3'd1;
    localparam logic [2:0] FN_O  = 3'd2;
    localparam logic [2:0] FN_X  = 3'd3;
    localparam logic [2:0] FN_DU = 3'd4;
    localparam logic [2:0] FN_OU = 3'd5;
    localparam logic [2:0] FN_XU = 3'd6;

    typedef enum logic [1:0] {
        RDX_10 = 2'd0,
        RDX_8  = 2'd1,
        RDX_16 = 2'd2
    } t_radix;

    // ceil(2^35 / 10): exact quotient for any 32-bit unsigned dividend
    localparam logic [31:0] RECIP10 = 32'hCCCC_CCCD;
    localparam int          RECIP_SHIFT = 35;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_A     = 8'h61;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SPACE = 8'h20;

    function automatic logic [7:0] digit_char(input logic [3:0] d);
        logic [7:0] r;
        if (d < 4'd10) begin
            r = CH_ZERO + {4'd0, d};
        end else begin
            r = CH_A + {4'd0, d} - 8'd10;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: sv/i2a_div.sv
`default_nettype none

// Shared digit unit: one call yields quotient and remainder of the magnitude
// by the radix. Decimal uses a reciprocal multiply, registered at load.
module i2a_div import i2a_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_load,
    input  wire logic [31:0] i_mag,
    input  wire t_radix      i_radix,
    output logic      [31:0] o_quo,
    output logic      [3:0]  o_rem
);

    localparam int Q10_W = 64 - RECIP_SHIFT;

    logic [31:0]      r_mag;
    t_radix           r_radix;
    logic [Q10_W-1:0] r_q10;
    logic [63:0]      prod;
    logic [31:0]      q10;
    logic [31:0]      rem10;

    assign prod = i_mag * RECIP10;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_mag   <= i_mag;
            r_radix <= i_radix;
            r_q10   <= prod[63:RECIP_SHIFT];
        end
    end

    assign q10   = 32'(r_q10);
    // remainder is below ten, so the low four bits are exact
    assign rem10 = r_mag - {q10[28:0], 3'b000} - {q10[30:0], 1'b0};

    always_comb begin
        case (r_radix)
            RDX_8: begin
                o_quo = {3'd0, r_mag[31:3]};
                o_rem = {1'b0, r_mag[2:0]};
            end
            RDX_16: begin
                o_quo = {4'd0, r_mag[31:4]};
                o_rem = r_mag[3:0];
            end
            default: begin
                o_quo = q10;
                o_rem = rem10[3:0];
            end
        endcase
    end

endmodule

`default_nettype wire

// File: sv/integer_to_padded_ascii_unit.sv
`default_nettype none

// Channel   Dir  Handshake                 Payload
// request   in   i_s_tvalid / o_s_tready   tuser: func; tdata: value, width, precision, zero_pad
// char      out  o_m_tvalid / i_m_tready   tdata: out_char; tlast: last
//
// One request at a time. After acceptance each digit passes the shared divide
// unit in S_MUL (multiply), then S_DIG (remainder), a minus sign takes S_SIGN,
// then setup runs in S_CALC; every character then leaves at one per cycle while
// the sink is ready.
// Synchronous active-low reset clears the sequencer and the output valid.
// A stalled sink holds the current character and pauses the sequencer's output states.
module integer_to_padded_ascii_unit import i2a_pkg::*; #(
    parameter int DIGIT_BUFFER = 12
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [47:0] i_s_tdata,  // [31:0] value, [38:32] width,
                                         // [44:39] precision, [45] zero_pad
    input  wire logic [2:0]  i_s_tuser,  // [2:0] func
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic      [7:0]  o_m_tdata,  // [7:0] out_char
    output logic             o_m_tlast
);

    localparam int                DEPTH   = DIGIT_BUFFER - 1;
    localparam int                IDX_W   = $clog2(DEPTH);
    localparam int                LEN_W   = $clog2(DIGIT_BUFFER);
    localparam logic [LEN_W-1:0]  LEN_MAX = LEN_W'(DEPTH);

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_MUL  = 9'b000000010,
        S_DIG  = 9'b000000100,
        S_SIGN = 9'b000001000,
        S_CALC = 9'b000010000,
        S_LPAD = 9'b000100000,
        S_NUM  = 9'b001000000,
        S_DOT  = 9'b010000000,
        S_RPAD = 9'b100000000
    } t_state;

    t_state              r_state, n_state;
    logic [31:0]         r_mag, n_mag;
    t_radix              r_radix, n_radix;
    logic                r_minus, n_minus;
    logic signed [6:0]   r_w1, n_w1;
    logic [5:0]          r_prec, n_prec;
    logic                r_zp, n_zp;
    logic [LEN_W-1:0]    r_len, n_len;
    logic [IDX_W-1:0]    r_top, n_top;
    logic [5:0]          r_cnt, n_cnt;
    logic [5:0]          r_lpad, n_lpad;
    logic [5:0]          r_rpad, n_rpad;
    logic                r_dot, n_dot;
    logic [7:0]          r_buf [DEPTH];
    logic                r_out_valid;
    logic [7:0]          r_out_char;
    logic                r_out_last;

    // request fields
    logic [2:0]          in_func;
    logic [31:0]         in_value;
    logic signed [6:0]   in_width;
    logic [5:0]          in_prec;
    logic                in_zp;

    // decoded request
    logic [31:0]         dec_mag;
    t_radix              dec_radix;
    logic                dec_minus;

    // divide unit
    logic                div_load;
    logic [31:0]         div_quo;
    logic [3:0]          div_rem;

    // digit stack
    logic                buf_we;
    logic [7:0]          buf_wdata;
    logic [LEN_W-1:0]    len_inc;
    logic                len_full;

    // setup arithmetic
    logic [5:0]          keep6;
    logic signed [7:0]   w8, k8, lp8, rp8;
    logic                calc_dot;

    // output
    logic                can_emit, emit, emit_last;
    logic [7:0]          emit_char, pad_char;

    assign in_func  = i_s_tuser;
    assign in_value = i_s_tdata[31:0];
    assign in_width = i_s_tdata[38:32];
    assign in_prec  = i_s_tdata[44:39];
    assign in_zp    = i_s_tdata[45];

    always_comb begin
        dec_mag   = in_value;
        dec_radix = RDX_10;
        dec_minus = 1'b0;
        case (in_func)
            FN_U: begin
                dec_mag = {16'd0, in_value[15:0]};
            end
            FN_O: begin
                dec_radix = RDX_8;
                if (in_value[31]) dec_mag = {16'd0, in_value[15:0]};
            end
            FN_X: begin
                dec_radix = RDX_16;
                if (in_value[31]) dec_mag = {16'd0, in_value[15:0]};
            end
            FN_OU: dec_radix = RDX_8;
            FN_XU: dec_radix = RDX_16;
            default: begin
                // d, D and the unused kind
                dec_minus = in_value[31];
                if (in_value[31]) dec_mag = 32'd0 - in_value;
            end
        endcase
    end

    i2a_div u_div (
        .i_clk   (i_clk),
        .i_load  (div_load),
        .i_mag   (r_mag),
        .i_radix (r_radix),
        .o_quo   (div_quo),
        .o_rem   (div_rem)
    );

    assign len_inc  = r_len + 1'b1;
    assign len_full = (len_inc == LEN_MAX);

    assign keep6    = (r_prec != 6'd0 && 6'(r_len) > r_prec) ? r_prec : 6'(r_len);
    assign w8       = {r_w1[6], r_w1};
    assign k8       = {2'b00, keep6};
    assign calc_dot = r_w1[6] & r_zp;
    assign lp8      = w8 - k8;
    assign rp8      = 8'sd0 - w8 - k8 - {7'd0, calc_dot};

    assign pad_char = r_zp ? CH_ZERO : CH_SPACE;
    assign can_emit = ~r_out_valid | i_m_tready;
    assign o_s_tready = (r_state == S_IDLE);

    always_comb begin
        n_state   = r_state;
        n_mag     = r_mag;
        n_radix   = r_radix;
        n_minus   = r_minus;
        n_w1      = r_w1;
        n_prec    = r_prec;
        n_zp      = r_zp;
        n_len     = r_len;
        n_top     = r_top;
        n_cnt     = r_cnt;
        n_lpad    = r_lpad;
        n_rpad    = r_rpad;
        n_dot     = r_dot;
        div_load  = 1'b0;
        buf_we    = 1'b0;
        buf_wdata = digit_char(div_rem);
        emit      = 1'b0;
        emit_char = pad_char;
        emit_last = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_mag   = dec_mag;
                    n_radix = dec_radix;
                    n_minus = dec_minus;
                    // clamp minus sixty-four to minus sixty-three
                    n_w1    = (in_width == -7'sd64) ? -7'sd63 : in_width;
                    n_prec  = in_prec;
                    n_zp    = in_zp;
                    n_len   = '0;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                div_load = 1'b1;
                n_state  = S_DIG;
            end
            S_DIG: begin
                buf_we = 1'b1;
                n_len  = len_inc;
                n_mag  = div_quo;
                if (div_quo == 32'd0 || len_full) begin
                    n_state = (r_minus && !len_full) ? S_SIGN : S_CALC;
                end else begin
                    n_state = S_MUL;
                end
            end
            S_SIGN: begin
                buf_we    = 1'b1;
                buf_wdata = CH_MINUS;
                n_len     = len_inc;
                n_state   = S_CALC;
            end
            S_CALC: begin
                n_cnt   = keep6;
                n_top   = IDX_W'(r_len - 1'b1);
                n_dot   = calc_dot;
                n_lpad  = (w8 > k8) ? lp8[5:0] : 6'd0;
                n_rpad  = (w8 < 8'sd0 && rp8 > 8'sd0) ? rp8[5:0] : 6'd0;
                n_state = (w8 > k8) ? S_LPAD : S_NUM;
            end
            S_LPAD: begin
                if (can_emit) begin
                    emit   = 1'b1;
                    n_lpad = r_lpad - 1'b1;
                    if (r_lpad == 6'd1) n_state = S_NUM;
                end
            end
            S_NUM: begin
                emit_char = r_buf[r_top];
                emit_last = (r_cnt == 6'd1) && !r_dot && (r_rpad == 6'd0);
                if (can_emit) begin
                    emit  = 1'b1;
                    n_top = r_top - 1'b1;
                    n_cnt = r_cnt - 1'b1;
                    if (r_cnt == 6'd1) begin
                        if (r_dot) begin
                            n_state = S_DOT;
                        end else if (r_rpad != 6'd0) begin
                            n_state = S_RPAD;
                        end else begin
                            n_state = S_IDLE;
                        end
                    end
                end
            end
            S_DOT: begin
                emit_char = CH_DOT;
                emit_last = (r_rpad == 6'd0);
                if (can_emit) begin
                    emit    = 1'b1;
                    n_state = (r_rpad == 6'd0) ? S_IDLE : S_RPAD;
                end
            end
            S_RPAD: begin
                emit_last = (r_rpad == 6'd1);
                if (can_emit) begin
                    emit   = 1'b1;
                    n_rpad = r_rpad - 1'b1;
                    if (r_rpad == 6'd1) n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag   <= n_mag;
        r_radix <= n_radix;
        r_minus <= n_minus;
        r_w1    <= n_w1;
        r_prec  <= n_prec;
        r_zp    <= n_zp;
        r_len   <= n_len;
        r_top   <= n_top;
        r_cnt   <= n_cnt;
        r_lpad  <= n_lpad;
        r_rpad  <= n_rpad;
        r_dot   <= n_dot;
        if (buf_we) r_buf[r_len[IDX_W-1:0]] <= buf_wdata;
        if (emit) begin
            r_out_char <= emit_char;
            r_out_last <= emit_last;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_char;
    assign o_m_tlast  = r_out_last;

endmodule

`default_nettype wire
